[hw/rtl/csa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the circuit switch port allocator.
package csa_pkg;

    localparam int POD_FIELD_W   = 8;
    localparam int SW_FIELD_W    = 8;
    localparam int MODE_W        = 2;
    localparam int PAIR_CNT_W    = 5;
    localparam int TOTAL_CNT_W   = 8;
    localparam int SPINE_W       = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 5;

    localparam logic [MODE_W-1:0] MODE_ACTIVATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_POD_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWITCH_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] POD_COUNT_RESET    = 5'd16;
    localparam logic [CFG_DATA_W-1:0] SWITCH_COUNT_RESET = 5'd16;

    localparam logic [PAIR_CNT_W-1:0]  PAIR_CNT_MAX  = 5'd31;
    localparam logic [TOTAL_CNT_W-1:0] TOTAL_CNT_MAX = 8'd255;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [POD_FIELD_W-1:0] pod_a;
        logic [POD_FIELD_W-1:0] pod_b;
        logic [SW_FIELD_W-1:0]  switch_id;
    } req_word_t;

    typedef struct packed {
        logic                   accepted;
        logic [PAIR_CNT_W-1:0]  pair_count;
        logic [TOTAL_CNT_W-1:0] total_count;
        logic [SPINE_W-1:0]     spine;
    } rsp_word_t;

endpackage

[hw/rtl/circuit_switch_port_allocator_core.sv]
`timescale 1ns / 1ps
// Circuit allocator for one optical switch plane: port busy maps and pair counts in RAM.
// Activate, query and mode three: a RAM read on accept, then a modify and write-back step that
// puts out the result; a waiting result holds the write-back, and no new word is taken meanwhile.
// Clear: a sweep over max(MAX_PODS*MAX_PODS, MAX_SWITCHES) rows, one RAM row per cycle, then write-back.
// Reset runs the same sweep with req_ready low; configuration writes are taken at any time.
// Registers reset to pod_count 16, switch_count 16.
module circuit_switch_port_allocator_core #(
    parameter int MAX_PODS     = 16,
    parameter int MAX_SWITCHES = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  csa_pkg::req_word_t                      req,
    output logic                                    rsp_valid,
    input  logic                                    rsp_ready,
    output csa_pkg::rsp_word_t                      rsp,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [csa_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]          cfg_data
);

    // Geometry of the two stores and the clearing sweep.
    localparam int POD_W      = (MAX_PODS > 1) ? $clog2(MAX_PODS) : 1;
    localparam int SW_W       = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;
    localparam int PAIR_DEPTH = MAX_PODS * MAX_PODS;
    localparam int PA_W       = $clog2(PAIR_DEPTH);
    localparam int CLR_LEN    = (PAIR_DEPTH > MAX_SWITCHES) ? PAIR_DEPTH : MAX_SWITCHES;
    localparam int CLR_W      = $clog2(CLR_LEN);

    // One-hot sequencer: sweep the RAMs, wait for a word, modify and write back.
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_RMW   = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [CLR_W-1:0]                    clr_cnt_reg, clr_cnt_next;
    logic                                clr_item_reg, clr_item_next;
    csa_pkg::req_word_t                  item_reg, item_next;
    logic [csa_pkg::TOTAL_CNT_W-1:0]     total_reg, total_next;
    logic [csa_pkg::CFG_DATA_W-1:0]      pod_count_reg, pod_count_next;
    logic [csa_pkg::CFG_DATA_W-1:0]      switch_count_reg, switch_count_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    csa_pkg::rsp_word_t                  rsp_reg, rsp_next;

    // Address path: the accepting cycle reads from the incoming word, the
    // write-back cycle writes to the same rows from the held word.
    csa_pkg::req_word_t                  addr_src;
    logic [POD_W-1:0]                    a_idx, b_idx, lo_idx, hi_idx;
    logic [PA_W-1:0]                     pair_addr;
    logic [SW_W-1:0]                     sw_addr;

    logic                                req_fire;
    logic                                out_free;
    logic                                clr_last;
    logic                                rmw_fire;

    // RAM ports
    logic                                pair_we, busy_we;
    logic [PA_W-1:0]                     pair_waddr;
    logic [SW_W-1:0]                     busy_waddr;
    logic [csa_pkg::PAIR_CNT_W-1:0]      pair_wdata, pair_rdata;
    logic [MAX_PODS-1:0]                 busy_wdata, busy_rdata;

    // Decision logic on the held word
    logic                                pods_ok, sw_ok, pod_hit, act_ok;
    logic [MAX_PODS-1:0]                 pod_bits;
    logic [csa_pkg::PAIR_CNT_W-1:0]      pair_val, pair_inc;
    logic [csa_pkg::TOTAL_CNT_W-1:0]     total_inc;

    assign req_fire  = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign clr_last  = (clr_cnt_reg == CLR_W'(CLR_LEN - 1));
    assign rmw_fire  = (state_reg == S_RMW) && out_free;

    always_comb
    begin
        addr_src = (state_reg == S_IDLE) ? req : item_reg;
        a_idx    = addr_src.pod_a[POD_W-1:0];
        b_idx    = addr_src.pod_b[POD_W-1:0];
        lo_idx   = (addr_src.pod_a < addr_src.pod_b) ? a_idx : b_idx;
        hi_idx   = (addr_src.pod_a < addr_src.pod_b) ? b_idx : a_idx;
        // Unordered pair row: lower pod times row length plus higher pod.
        pair_addr = PA_W'(PA_W'(lo_idx) * PA_W'(MAX_PODS)) + PA_W'(hi_idx);
        sw_addr   = addr_src.switch_id[SW_W-1:0];
    end

    // Range checks against both the register and the built-in size.
    always_comb
    begin
        pods_ok = (item_reg.pod_a < {3'b000, pod_count_reg})
               && (item_reg.pod_b < {3'b000, pod_count_reg})
               && (32'(item_reg.pod_a) < MAX_PODS)
               && (32'(item_reg.pod_b) < MAX_PODS);
        sw_ok   = (item_reg.switch_id < {3'b000, switch_count_reg})
               && (32'(item_reg.switch_id) < MAX_SWITCHES);
        pod_bits = (MAX_PODS'(1) << item_reg.pod_a[POD_W-1:0])
                 | (MAX_PODS'(1) << item_reg.pod_b[POD_W-1:0]);
        pod_hit  = |(busy_rdata & pod_bits);
        act_ok   = (item_reg.mode == csa_pkg::MODE_ACTIVATE)
                && (item_reg.pod_a != item_reg.pod_b)
                && pods_ok && sw_ok && !pod_hit;
        pair_val  = pods_ok ? pair_rdata : '0;
        // Saturate both counters.
        pair_inc  = (pair_rdata == csa_pkg::PAIR_CNT_MAX) ? pair_rdata
                                                          : pair_rdata + 1'b1;
        total_inc = (total_reg == csa_pkg::TOTAL_CNT_MAX) ? total_reg
                                                          : total_reg + 1'b1;
    end

    // Write ports: the sweep zeroes one row per cycle, else write back on success.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            pair_we    = (32'(clr_cnt_reg) < PAIR_DEPTH);
            pair_waddr = clr_cnt_reg[PA_W-1:0];
            pair_wdata = '0;
            busy_we    = (32'(clr_cnt_reg) < MAX_SWITCHES);
            busy_waddr = clr_cnt_reg[SW_W-1:0];
            busy_wdata = '0;
        end
        else
        begin
            pair_we    = rmw_fire && act_ok;
            pair_waddr = pair_addr;
            pair_wdata = pair_inc;
            busy_we    = rmw_fire && act_ok;
            busy_waddr = sw_addr;
            busy_wdata = busy_rdata | pod_bits;
        end
    end

    csa_ram #(
        .WIDTH (csa_pkg::PAIR_CNT_W),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .re    (req_fire),
        .raddr (pair_addr),
        .rdata (pair_rdata)
    );

    csa_ram #(
        .WIDTH (MAX_PODS),
        .DEPTH (MAX_SWITCHES)
    ) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (req_fire),
        .raddr (sw_addr),
        .rdata (busy_rdata)
    );

    // Sequencer and result register.
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        clr_item_next     = clr_item_reg;
        item_next         = item_reg;
        total_next        = total_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_next          = rsp_reg;
        pod_count_next    = pod_count_reg;
        switch_count_next = switch_count_reg;

        // Drop the result once it is taken.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == csa_pkg::CFG_POD_COUNT)
            begin
                pod_count_next = cfg_data;
            end
            else if (cfg_index == csa_pkg::CFG_SWITCH_COUNT)
            begin
                switch_count_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_item_reg ? S_RMW : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    item_next = req;
                    if (req.mode == csa_pkg::MODE_CLEAR)
                    begin
                        clr_item_next = 1'b1;
                        clr_cnt_next  = '0;
                        total_next    = '0;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_RMW;
                    end
                end
            end
            S_RMW:
            begin
                // Hold until the result register is free, then commit.
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.spine       = item_reg.switch_id[csa_pkg::SPINE_W-1:0];
                    rsp_next.accepted    = act_ok
                                        || (item_reg.mode == csa_pkg::MODE_QUERY)
                                        || (item_reg.mode == csa_pkg::MODE_CLEAR);
                    rsp_next.pair_count  = act_ok ? pair_inc : pair_val;
                    rsp_next.total_count = act_ok ? total_inc : total_reg;
                    if (item_reg.mode == csa_pkg::MODE_CLEAR)
                    begin
                        rsp_next.pair_count = '0;
                    end
                    if (act_ok)
                    begin
                        total_next = total_inc;
                    end
                    clr_item_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            clr_item_reg     <= 1'b0;
            total_reg        <= '0;
            rsp_valid_reg    <= 1'b0;
            pod_count_reg    <= csa_pkg::POD_COUNT_RESET;
            switch_count_reg <= csa_pkg::SWITCH_COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            clr_item_reg     <= clr_item_next;
            total_reg        <= total_next;
            rsp_valid_reg    <= rsp_valid_next;
            pod_count_reg    <= pod_count_next;
            switch_count_reg <= switch_count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    // A new result only comes out of the write-back step.
    a_rsp_from_rmw : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RMW))
        else $error("result appeared without a write-back step");

    // A refused or non-activate word leaves the plane total alone.
    a_total_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (rmw_fire && !act_ok) |=> $stable(total_reg))
        else $error("plane total changed on a refused word");

    // A clear word reaches write-back only with the total emptied.
    a_clear_total : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW && item_reg.mode == csa_pkg::MODE_CLEAR) |-> (total_reg == '0))
        else $error("plane total not zero after clear sweep");

    // No word is taken while the sweep runs.
    a_no_accept_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !$past(req_fire))
        else $error("word accepted during clear sweep");

endmodule

[hw/rtl/csa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the circuit switch port allocator core.
module tb;
    import csa_pkg::*;

    localparam int MAX_PODS     = 16;
    localparam int MAX_SWITCHES = 16;
    localparam int SPINES       = 4;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 200;

    // Mode three has no name in the package; the core must ignore it.
    localparam logic [MODE_W-1:0]      MODE_UNUSED = 2'd3;
    // Register indexes past the end of the list; writes to them are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Scoreboard: keeps its own copy of the plane (busy maps, pair counts,
    // total, registers), predicts the response word for every accepted
    // request word, and compares responses in order.
    class allocation_board;
        logic [MAX_PODS-1:0]    port_busy [MAX_SWITCHES];
        logic [PAIR_CNT_W-1:0]  pair_circuits [MAX_PODS*MAX_PODS];
        logic [TOTAL_CNT_W-1:0] plane_total;
        logic [CFG_DATA_W-1:0]  pod_count;
        logic [CFG_DATA_W-1:0]  switch_count;
        rsp_word_t              rsp_due [$];
        int                     error_count;

        function new();
            pod_count    = POD_COUNT_RESET;
            switch_count = SWITCH_COUNT_RESET;
            error_count  = 0;
            clear_plane();
        endfunction

        function void clear_plane();
            foreach (port_busy[i]) port_busy[i] = '0;
            foreach (pair_circuits[i]) pair_circuits[i] = '0;
            plane_total = '0;
        endfunction

        function int pod_limit();
            return (int'(pod_count) < MAX_PODS) ? int'(pod_count) : MAX_PODS;
        endfunction

        function int switch_limit();
            return (int'(switch_count) < MAX_SWITCHES) ? int'(switch_count) : MAX_SWITCHES;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POD_COUNT:    pod_count = data;
                CFG_SWITCH_COUNT: switch_count = data;
                default: ;
            endcase
        endfunction

        function bit pods_valid(int a, int b);
            return (a < pod_limit()) && (b < pod_limit());
        endfunction

        function int pair_slot(int a, int b);
            int lo;
            int hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return lo * MAX_PODS + hi;
        endfunction

        function logic [PAIR_CNT_W-1:0] pair_value(int a, int b);
            if (!pods_valid(a, b))
                return '0;
            return pair_circuits[pair_slot(a, b)];
        endfunction

        function bit activate(int a, int b, int s);
            logic [MAX_PODS-1:0] bits;
            int slot;
            if (a == b || !pods_valid(a, b) || s >= switch_limit())
                return 1'b0;
            bits    = '0;
            bits[a] = 1'b1;
            bits[b] = 1'b1;
            if ((port_busy[s] & bits) != '0)
                return 1'b0;
            port_busy[s] = port_busy[s] | bits;
            slot = pair_slot(a, b);
            if (pair_circuits[slot] < PAIR_CNT_MAX)
                pair_circuits[slot] = pair_circuits[slot] + 1'b1;
            if (plane_total < TOTAL_CNT_MAX)
                plane_total = plane_total + 1'b1;
            return 1'b1;
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t e;
            int a;
            int b;
            int s;
            a = int'(w.pod_a);
            b = int'(w.pod_b);
            s = int'(w.switch_id);
            case (w.mode)
                MODE_ACTIVATE:
                begin
                    e.accepted   = activate(a, b, s);
                    e.pair_count = pair_value(a, b);
                end
                MODE_QUERY:
                begin
                    e.accepted   = 1'b1;
                    e.pair_count = pair_value(a, b);
                end
                MODE_CLEAR:
                begin
                    clear_plane();
                    e.accepted   = 1'b1;
                    e.pair_count = '0;
                end
                default:
                begin
                    e.accepted   = 1'b0;
                    e.pair_count = pair_value(a, b);
                end
            endcase
            e.total_count = plane_total;
            e.spine       = SPINE_W'(s % SPINES);
            rsp_due.insert(rsp_due.size(), e);
        endfunction

        task report_error(string msg);
            $display("error at %0t ns: %s", $time, msg);
            error_count++;
        endtask

        task check_response(rsp_word_t got);
            rsp_word_t want;
            if (rsp_due.size() == 0)
            begin
                report_error($sformatf("response %h with nothing outstanding", got));
                return;
            end
            want = rsp_due.pop_front();
            if (got.accepted !== want.accepted)
                report_error($sformatf("accepted got %0d expected %0d",
                                       got.accepted, want.accepted));
            if (got.pair_count !== want.pair_count)
                report_error($sformatf("pair_count got %0d expected %0d",
                                       got.pair_count, want.pair_count));
            if (got.total_count !== want.total_count)
                report_error($sformatf("total_count got %0d expected %0d",
                                       got.total_count, want.total_count));
            if (got.spine !== want.spine)
                report_error($sformatf("spine got %0d expected %0d",
                                       got.spine, want.spine));
        endtask

        task check_leftover();
            if (rsp_due.size() != 0)
                report_error($sformatf("%0d responses never arrived", rsp_due.size()));
        endtask

        function int outstanding();
            return rsp_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_word_t              req = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_word_t              rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    allocation_board board;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic holding = 1'b0;
    int  cycle_count = 0;
    int  pod_order [MAX_PODS];

    // Per-phase idling and register settings; the extremes 0 and 31 are in here.
    int send_pct_set  [NUM_PHASES] = '{0, 65, 0, 24, 0, 24};
    int recv_pct_set  [NUM_PHASES] = '{0, 0, 65, 24, 0, 24};
    int pod_set       [NUM_PHASES] = '{16, 31, 9, 16, 16, 0};
    int switch_set    [NUM_PHASES] = '{16, 31, 5, 1, 16, 0};

    circuit_switch_port_allocator_core #(
        .MAX_PODS     (MAX_PODS),
        .MAX_SWITCHES (MAX_SWITCHES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Abort a hung run; the limit is far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely while a hold-off runs.
    always @(posedge clk)
    begin
        if (holding)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check the response word first, then note the request word,
    // both on pre-edge values, so the order against the driver never matters.
    always @(posedge clk)
    begin
        if (rst_n && board != null)
        begin
            if (rsp_valid && rsp_ready)
                board.check_response(rsp);
            if (req_valid && req_ready)
                board.note_request(req);
        end
    end

    // Hold the receiver off in a process of its own; n sets how long.
    task automatic hold_receiver(int n);
        holding <= 1'b1;
        repeat (n) @(posedge clk);
        holding <= 1'b0;
    endtask

    function automatic req_word_t make_word(logic [MODE_W-1:0] mode, int a, int b, int s);
        req_word_t w;
        w.mode      = mode;
        w.pod_a     = POD_FIELD_W'(a);
        w.pod_b     = POD_FIELD_W'(b);
        w.switch_id = SW_FIELD_W'(s);
        return w;
    endfunction

    // Offer one request word; call at a rising edge, returns at the edge that
    // accepts it with valid still high, so back-to-back words keep valid up.
    task automatic send_word(req_word_t w);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the core is idle; the model follows on accept.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.write_register(idx, data);
    endtask

    // Fill one element: pair up a shuffled set of all pods so every port on it
    // gets used, then query one of the new pairs. Repeated runs load the plane.
    task automatic fill_switch();
        int s;
        int j;
        int t;
        s = (board.switch_limit() > 0) ? $urandom_range(board.switch_limit() - 1)
                                       : $urandom_range(MAX_SWITCHES - 1);
        for (int i = 0; i < MAX_PODS; i++)
            pod_order[i] = i;
        for (int i = MAX_PODS - 1; i > 0; i--)
        begin
            j            = $urandom_range(i);
            t            = pod_order[i];
            pod_order[i] = pod_order[j];
            pod_order[j] = t;
        end
        for (int k = 0; k < MAX_PODS / 2; k++)
            send_word(make_word(MODE_ACTIVATE, pod_order[2*k], pod_order[2*k+1], s));
        j = $urandom_range(MAX_PODS / 2 - 1);
        send_word(make_word(MODE_QUERY, pod_order[2*j+1], pod_order[2*j], $urandom_range(255)));
    endtask

    // One loose word: mostly in-range activates and queries, some rare clears,
    // mode three, and indices that reach every bit of the 8-bit fields.
    function automatic req_word_t random_word();
        req_word_t w;
        int r;
        r = $urandom_range(99);
        if (r < 50)
            w.mode = MODE_ACTIVATE;
        else if (r < 88)
            w.mode = MODE_QUERY;
        else if (r < 90)
            w.mode = MODE_CLEAR;
        else if (r < 95)
            w.mode = MODE_UNUSED;
        else
            w.mode = MODE_W'($urandom_range(3));
        w.pod_a     = ($urandom_range(99) < 85) ? POD_FIELD_W'($urandom_range(15))
                                                : POD_FIELD_W'($urandom_range(255));
        w.pod_b     = ($urandom_range(99) < 85) ? POD_FIELD_W'($urandom_range(15))
                                                : POD_FIELD_W'($urandom_range(255));
        w.switch_id = ($urandom_range(99) < 85) ? SW_FIELD_W'($urandom_range(15))
                                                : SW_FIELD_W'($urandom_range(255));
        return w;
    endfunction

    task automatic run_random(int quota);
        for (int n = 0; n < quota; )
        begin
            if ($urandom_range(99) < 35)
            begin
                fill_switch();
                n += MAX_PODS / 2 + 1;
            end
            else
            begin
                send_word(random_word());
                n++;
            end
        end
    endtask

    // Directed words at reset settings: accept, reversed pair, busy port,
    // equal pods, out-of-range pod and element, query, mode three, clear.
    task automatic run_directed();
        send_word(make_word(MODE_QUERY,    0,   0,   0));
        send_word(make_word(MODE_ACTIVATE, 0,   1,   0));
        send_word(make_word(MODE_ACTIVATE, 1,   0,   1));
        send_word(make_word(MODE_ACTIVATE, 0,   2,   0));
        send_word(make_word(MODE_ACTIVATE, 1,   0,   0));
        send_word(make_word(MODE_ACTIVATE, 3,   3,   2));
        send_word(make_word(MODE_ACTIVATE, 15,  14,  15));
        send_word(make_word(MODE_ACTIVATE, 16,  2,   3));
        send_word(make_word(MODE_ACTIVATE, 255, 255, 255));
        send_word(make_word(MODE_ACTIVATE, 4,   5,   16));
        send_word(make_word(MODE_ACTIVATE, 6,   200, 4));
        send_word(make_word(MODE_ACTIVATE, 128, 64,  7));
        send_word(make_word(MODE_QUERY,    1,   0,   255));
        send_word(make_word(MODE_QUERY,    255, 0,   1));
        send_word(make_word(MODE_QUERY,    7,   7,   2));
        send_word(make_word(MODE_UNUSED,   0,   1,   6));
        send_word(make_word(MODE_UNUSED,   255, 255, 255));
        send_word(make_word(MODE_CLEAR,    0,   1,   170));
        send_word(make_word(MODE_QUERY,    0,   1,   0));
        send_word(make_word(MODE_ACTIVATE, 0,   1,   0));
        send_word(make_word(MODE_ACTIVATE, 3,   4,   1));
        drain();
        // Shrink the pod range: the 3-4 circuit stays counted but is hidden.
        write_register(CFG_POD_COUNT, 5'd2);
        send_word(make_word(MODE_QUERY,    3,   4,   0));
        send_word(make_word(MODE_ACTIVATE, 0,   1,   5));
        drain();
        write_register(CFG_POD_COUNT, 5'd16);
        send_word(make_word(MODE_QUERY,    4,   3,   0));
        send_word(make_word(MODE_CLEAR,    0,   0,   0));
        drain();
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = send_pct_set[p];
            recv_stall_pct = recv_pct_set[p];
            write_register(CFG_POD_COUNT, CFG_DATA_W'(pod_set[p]));
            write_register(CFG_SWITCH_COUNT, CFG_DATA_W'(switch_set[p]));
            if (p == 2)
            begin
                write_register(CFG_SPARE_2, CFG_DATA_W'($urandom_range(31)));
                write_register(CFG_SPARE_3, CFG_DATA_W'($urandom_range(31)));
            end
            // Back-pressure: hold the receiver while the sender keeps offering.
            if (p == 4)
            begin
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            end
            run_random(PHASE_ITEMS);
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (8) @(posedge clk);
        board.check_leftover();
        if (board.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[circuit_switch_port_allocator_core.f]
hw/rtl/csa_pkg.sv
hw/rtl/csa_ram.sv
hw/rtl/circuit_switch_port_allocator_core.sv
tb/sv/tb.sv
